>>> rtl/core/diwseq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// diwseq_pkg: shared types and constants for the display I2C write sequencer
// Request codes, I2C schedule phases, hold times and the sequencer state word.
// ----------------------------------------------------------------------------
package diwseq_pkg;

	// Request codes carried in the kind field
	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_CMD  = 2'd1;
	localparam logic [1:0] KIND_DATA = 2'd2;

	// Control bytes and address at reset
	localparam logic [7:0] CTRL_CMD   = 8'h00;
	localparam logic [7:0] CTRL_DATA  = 8'h40;
	localparam logic [7:0] ADDR_RESET = 8'h78;

	// Hold times in microsecond ticks
	localparam logic [3:0] T_SETUP     = 4'd2;
	localparam logic [3:0] T_HALF      = 4'd5;
	localparam logic [3:0] T_GAP       = 4'd2;
	localparam logic [3:0] T_TAIL_CMD  = 4'd10;
	localparam logic [3:0] T_TAIL_DATA = 4'd5;
	localparam logic [3:0] T_START_LOW = T_HALF + T_SETUP;
	localparam logic [3:0] T_ACK_LOW   = T_SETUP + T_GAP;
	localparam logic [3:0] T_STOP_CMD  = T_HALF + T_TAIL_CMD;
	localparam logic [3:0] T_STOP_DATA = T_HALF + T_TAIL_DATA;

	// Schedule phases
	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_START_A   = 4'd1,
		PH_START_B   = 4'd2,
		PH_START_C   = 4'd3,
		PH_BIT_SETUP = 4'd4,
		PH_BIT_HIGH  = 4'd5,
		PH_BIT_LOW   = 4'd6,
		PH_ACK_HIGH  = 4'd7,
		PH_ACK_LOW   = 4'd8,
		PH_STOP_A    = 4'd9,
		PH_STOP_TAIL = 4'd10
	} phase_t;

	// Sequencer state word
	typedef struct packed {
		phase_t     phase;
		logic [3:0] hold;
		logic [2:0] bit_pos;
		logic [1:0] byte_pos;
		logic [7:0] shift;
		logic [7:0] payload;
		logic       is_data;
		logic       scl;
		logic       sda;
	} seq_state_t;

	// Result word
	typedef struct packed {
		logic scl;
		logic sda;
		logic busy_res;
		logic rejected;
	} res_t;

endpackage
`default_nettype wire

>>> rtl/core/diwseq_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// diwseq_if: valid/ready channels of the display I2C write sequencer
// Request channel (kind, payload byte) and result channel (pin levels, flags).
// ----------------------------------------------------------------------------
interface diwseq_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] payload_byte;

	modport source (output valid, output kind, output payload_byte, input ready);
	modport sink (input valid, input kind, input payload_byte, output ready);
endinterface

interface diwseq_res_if;
	logic valid;
	logic ready;
	logic scl;
	logic sda;
	logic busy_res;
	logic rejected;

	modport source (output valid, output scl, output sda, output busy_res,
		output rejected, input ready);
	modport sink (input valid, input scl, input sda, input busy_res,
		input rejected, output ready);
endinterface
`default_nettype wire

>>> rtl/core/diwseq_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// diwseq_step: one step of the I2C write schedule
// Takes the current state and one request or tick, gives the next state and
// the result word (pin levels, busy, rejected).
// ----------------------------------------------------------------------------
module diwseq_step (
	input  wire diwseq_pkg::seq_state_t cur,
	input  wire logic [1:0]             kind,
	input  wire logic [7:0]             payload_byte,
	input  wire logic [7:0]             device_address,
	output diwseq_pkg::seq_state_t      nxt,
	output diwseq_pkg::res_t            res
);

	logic       is_req;
	logic       rej_c;
	logic [3:0] hold_dec;
	logic [1:0] ld_pos;
	logic [7:0] ld_byte;
	logic [7:0] shifted;

	assign is_req   = (kind == diwseq_pkg::KIND_CMD) || (kind == diwseq_pkg::KIND_DATA);
	assign hold_dec = (cur.hold != 4'd0) ? (cur.hold - 4'd1) : 4'd0;
	assign shifted  = {cur.shift[6:0], 1'b0};

	// Pick the byte slot to load next: address after start, else the following slot
	assign ld_pos = (cur.phase == diwseq_pkg::PH_START_C) ? 2'd0 : (cur.byte_pos + 2'd1);

	always_comb begin
		case (ld_pos)
			2'd0: ld_byte = device_address;
			2'd1: ld_byte = cur.is_data ? diwseq_pkg::CTRL_DATA : diwseq_pkg::CTRL_CMD;
			default: ld_byte = cur.payload;
		endcase
	end

	// Next state: start a transaction, drop a request while busy, or advance on a tick
	always_comb begin
		nxt   = cur;
		rej_c = 1'b0;
		if (is_req) begin
			if (cur.phase != diwseq_pkg::PH_IDLE) begin
				rej_c = 1'b1;
			end else begin
				nxt.payload  = payload_byte;
				nxt.is_data  = (kind == diwseq_pkg::KIND_DATA);
				nxt.sda      = 1'b1;
				nxt.scl      = 1'b1;
				nxt.bit_pos  = 3'd0;
				nxt.byte_pos = 2'd0;
				nxt.hold     = diwseq_pkg::T_HALF;
				nxt.phase    = diwseq_pkg::PH_START_A;
			end
		end else if (cur.phase != diwseq_pkg::PH_IDLE) begin
			nxt.hold = hold_dec;
			if (hold_dec == 4'd0) begin
				case (cur.phase)
					diwseq_pkg::PH_START_A: begin
						nxt.sda   = 1'b0;
						nxt.hold  = diwseq_pkg::T_HALF;
						nxt.phase = diwseq_pkg::PH_START_B;
					end
					diwseq_pkg::PH_START_B: begin
						nxt.scl   = 1'b0;
						nxt.hold  = diwseq_pkg::T_START_LOW;
						nxt.phase = diwseq_pkg::PH_START_C;
					end
					diwseq_pkg::PH_START_C: begin
						nxt.byte_pos = ld_pos;
						nxt.shift    = ld_byte;
						nxt.bit_pos  = 3'd0;
						nxt.sda      = ld_byte[7];
						nxt.hold     = diwseq_pkg::T_SETUP;
						nxt.phase    = diwseq_pkg::PH_BIT_SETUP;
					end
					diwseq_pkg::PH_BIT_SETUP: begin
						nxt.scl   = 1'b1;
						nxt.hold  = diwseq_pkg::T_HALF;
						nxt.phase = diwseq_pkg::PH_BIT_HIGH;
					end
					diwseq_pkg::PH_BIT_HIGH: begin
						nxt.scl   = 1'b0;
						nxt.hold  = diwseq_pkg::T_HALF;
						nxt.phase = diwseq_pkg::PH_BIT_LOW;
					end
					diwseq_pkg::PH_BIT_LOW: begin
						if (cur.bit_pos != 3'd7) begin
							nxt.bit_pos = cur.bit_pos + 3'd1;
							nxt.shift   = shifted;
							nxt.sda     = shifted[7];
							nxt.hold    = diwseq_pkg::T_SETUP;
							nxt.phase   = diwseq_pkg::PH_BIT_SETUP;
						end else begin
							nxt.scl   = 1'b1;
							nxt.hold  = diwseq_pkg::T_HALF;
							nxt.phase = diwseq_pkg::PH_ACK_HIGH;
						end
					end
					diwseq_pkg::PH_ACK_HIGH: begin
						nxt.scl   = 1'b0;
						nxt.hold  = diwseq_pkg::T_ACK_LOW;
						nxt.phase = diwseq_pkg::PH_ACK_LOW;
					end
					diwseq_pkg::PH_ACK_LOW: begin
						if (cur.byte_pos != 2'd2) begin
							nxt.byte_pos = ld_pos;
							nxt.shift    = ld_byte;
							nxt.bit_pos  = 3'd0;
							nxt.sda      = ld_byte[7];
							nxt.hold     = diwseq_pkg::T_SETUP;
							nxt.phase    = diwseq_pkg::PH_BIT_SETUP;
						end else begin
							nxt.sda   = 1'b0;
							nxt.scl   = 1'b1;
							nxt.hold  = diwseq_pkg::T_HALF;
							nxt.phase = diwseq_pkg::PH_STOP_A;
						end
					end
					diwseq_pkg::PH_STOP_A: begin
						nxt.sda   = 1'b1;
						nxt.hold  = cur.is_data ? diwseq_pkg::T_STOP_DATA
							: diwseq_pkg::T_STOP_CMD;
						nxt.phase = diwseq_pkg::PH_STOP_TAIL;
					end
					default: begin
						// End of the idle tail, or a phase code with no meaning
						nxt.hold  = 4'd0;
						nxt.phase = diwseq_pkg::PH_IDLE;
					end
				endcase
			end
		end
	end

	// Result word from the next state
	always_comb begin
		res.scl      = nxt.scl;
		res.sda      = nxt.sda;
		res.busy_res = (nxt.phase != diwseq_pkg::PH_IDLE);
		res.rejected = rej_c;
	end

endmodule
`default_nettype wire

>>> rtl/core/display_i2c_write_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// display_i2c_write_sequencer: write-only I2C master for a display controller
// Plays start, address, control byte, payload and stop on SCL/SDA levels,
// one schedule step per microsecond tick item.
// ----------------------------------------------------------------------------
// Usage:
//   req (valid/ready): kind 0 is a one microsecond tick, kind 1 writes a
//   command byte, kind 2 a data byte (payload_byte). A request taken while a
//   transaction or its idle tail runs is dropped and reported as rejected.
//   res (valid/ready): one transaction per request transaction, carrying the
//   SCL and SDA levels after that item, busy_res and rejected.
//   cfg_we/cfg_wdata: writes device_address (0x78 after reset); write it only
//   while no transaction is in flight.
// Timing: the request lands in an input register, the schedule step runs
//   between that register and the result register, and the result is presented
//   from the result register. One item per cycle is taken sustained while
//   res.ready stays high; the schedule step updates the state once per item.
// Reset: arst_n clears the block to idle with both pins high and no result.
// Stall: while res is not taken the result register holds, the input register
//   still takes one more transaction, then req.ready drops.
// ----------------------------------------------------------------------------
module display_i2c_write_sequencer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	diwseq_req_if.sink      req,
	diwseq_res_if.source    res,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata
);

	logic                   valid_s1;
	logic [1:0]             kind_s1;
	logic [7:0]             payload_s1;
	logic                   valid_s2;
	diwseq_pkg::res_t       res_s2;
	diwseq_pkg::res_t       res_c;
	diwseq_pkg::seq_state_t state_q;
	diwseq_pkg::seq_state_t state_c;
	logic [7:0]             dev_addr_q;
	logic                   in_fire;
	logic                   adv;

	// Advance when the input stage holds an item and the result slot frees up
	assign adv      = valid_s1 && (!valid_s2 || res.ready);
	assign req.ready = !valid_s1 || adv;
	assign in_fire  = req.valid && req.ready;

	// Hold the device address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= diwseq_pkg::ADDR_RESET;
		end else if (cfg_we) begin
			dev_addr_q <= cfg_wdata;
		end
	end

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1    <= req.kind;
			payload_s1 <= req.payload_byte;
		end
	end

	diwseq_step u_step (
		.cur            (state_q),
		.kind           (kind_s1),
		.payload_byte   (payload_s1),
		.device_address (dev_addr_q),
		.nxt            (state_c),
		.res            (res_c)
	);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase    <= diwseq_pkg::PH_IDLE;
			state_q.hold     <= 4'd0;
			state_q.bit_pos  <= 3'd0;
			state_q.byte_pos <= 2'd0;
			state_q.shift    <= 8'd0;
			state_q.payload  <= 8'd0;
			state_q.is_data  <= 1'b0;
			state_q.scl      <= 1'b1;
			state_q.sda      <= 1'b1;
		end else if (adv) begin
			state_q <= state_c;
		end
	end

	// Result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_c;
		end
	end

	assign res.valid    = valid_s2;
	assign res.scl      = res_s2.scl;
	assign res.sda      = res_s2.sda;
	assign res.busy_res = res_s2.busy_res;
	assign res.rejected = res_s2.rejected;

	// A dropped request only happens while a transaction runs
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.rejected) |-> res_s2.busy_res)
		else $error("rejected result without busy");

	// Both pins rest high whenever the schedule is idle
	a_idle_pins: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == diwseq_pkg::PH_IDLE) |-> (state_q.scl && state_q.sda))
		else $error("pins not released in idle");

	// A request taken in idle starts a transaction and is not dropped
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (state_q.phase == diwseq_pkg::PH_IDLE)
			&& ((kind_s1 == diwseq_pkg::KIND_CMD) || (kind_s1 == diwseq_pkg::KIND_DATA)))
		|=> (res_s2.busy_res && !res_s2.rejected
			&& (state_q.phase == diwseq_pkg::PH_START_A)))
		else $error("request in idle did not start a transaction");

endmodule
`default_nettype wire
